FILE: rtl/core/ipnt_pkg.sv
// Shared types and codes for the IP-to-MAC neighbor table.
`default_nettype none
package ipnt_pkg;

  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int STAMP_W = 32;
  localparam int TOTAL_W = 6;

  // request kinds (in_tuser)
  localparam logic [1:0] REQ_LEARN    = 2'd0;
  localparam logic [1:0] REQ_FIND_IP  = 2'd1;
  localparam logic [1:0] REQ_FIND_MAC = 2'd2;
  localparam logic [1:0] REQ_DUMP     = 2'd3;

  // result status (out_tuser)
  localparam logic [1:0] STAT_HIT  = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_INS  = 2'd2;
  localparam logic [1:0] STAT_FULL = 2'd3;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [MAC_W-1:0]   mac;
    logic [IP_W-1:0]    ip;
  } entry_t;

  // per-cycle move of the whole chain
  typedef struct packed {
    logic rotate;  // every cell takes its upper neighbor, head wraps to the tail
    logic insert;  // every cell takes its lower neighbor, new entry enters the head
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/core/ipnt_cell.sv
// One table slot of the neighbor chain; passes its entry to a neighbor on a move.
`default_nettype none
module ipnt_cell (
  input  wire logic               clk,
  input  wire ipnt_pkg::cell_ctl_t ctl,
  input  wire ipnt_pkg::entry_t    from_next,
  input  wire ipnt_pkg::entry_t    from_prev,
  output ipnt_pkg::entry_t         q
);

  ipnt_pkg::entry_t entry_r;
  ipnt_pkg::entry_t entry_nxt;

  always_comb begin
    priority if (ctl.rotate) begin
      entry_nxt = from_next;
    end else if (ctl.insert) begin
      entry_nxt = from_prev;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q = entry_r;

endmodule
`default_nettype wire

FILE: rtl/core/ip_mac_neighbor_table_core.sv
// Top level: neighbor table as a rotating chain of entry cells plus request sequencer.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | tuser: req_type; tdata: ip, mac, stamp
//  out_    | out | out_tvalid/tready   | tuser: status; tdata: ip, mac, stamp, total; tlast
//
// A request is taken in the idle state, then the chain rotates TABLE_DEPTH times so every
// slot passes the head cell, newest first; the finish state follows (learn insert if room, last beat).
// The rotation moves one slot per cycle while the output is free; no new request is taken until idle.
// A stalled output register freezes the rotation until the beat is taken.
// Reset clears the entry count, sequencer and output valid; cell contents are not reset.
`default_nettype none
module ip_mac_neighbor_table_core #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [1:0]   in_tuser,   // [1:0] req_type
  input  wire logic [111:0] in_tdata,   // [31:0] ip_addr, [79:32] mac_addr, [111:80] stamp
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [1:0]        out_tuser,  // [1:0] status
  output logic [119:0]      out_tdata,  // [31:0] out_ip, [79:32] out_mac, [111:80] out_stamp,
                                        // [117:112] entry_total, [119:118] zero
  output logic              out_tlast
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  ipnt_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    step_r, step_nxt;
  logic [1:0]          req_r, req_nxt;
  ipnt_pkg::entry_t    key_r, key_nxt;
  ipnt_pkg::entry_t    pend_r, pend_nxt;   // dump: held beat; find: hit entry
  logic                pend_v_r, pend_v_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_stat_r, out_stat_nxt;
  ipnt_pkg::entry_t    out_ent_r, out_ent_nxt;
  logic [ipnt_pkg::TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic                out_last_r, out_last_nxt;

  ipnt_pkg::cell_ctl_t ctl;
  ipnt_pkg::entry_t    cell_q [TABLE_DEPTH];
  ipnt_pkg::entry_t    head;
  ipnt_pkg::entry_t    wrap;
  logic                slot_free;
  logic                in_use;
  logic                match;

  assign head      = cell_q[0];
  assign slot_free = !out_valid_r || out_tready;
  assign in_use    = step_r < count_r;
  assign match     = (req_r == ipnt_pkg::REQ_FIND_MAC) ? (head.mac == key_r.mac)
                                                       : (head.ip == key_r.ip);

  // count of entries as a 6-bit output field
  function automatic logic [ipnt_pkg::TOTAL_W-1:0] to_total(input logic [CNT_W-1:0] c);
    logic [CNT_W+ipnt_pkg::TOTAL_W-1:0] wide;
    wide = (CNT_W + ipnt_pkg::TOTAL_W)'(c);
    return wide[ipnt_pkg::TOTAL_W-1:0];
  endfunction

  generate
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      ipnt_pkg::entry_t nxt_in;
      ipnt_pkg::entry_t prv_in;
      if (i == TABLE_DEPTH - 1) begin : g_tail
        assign nxt_in = wrap;
      end else begin : g_mid_n
        assign nxt_in = cell_q[i+1];
      end
      if (i == 0) begin : g_head
        assign prv_in = key_r;
      end else begin : g_mid_p
        assign prv_in = cell_q[i-1];
      end
      ipnt_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .from_next (nxt_in),
        .from_prev (prv_in),
        .q         (cell_q[i])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_stat_nxt  = out_stat_r;
    out_ent_nxt   = out_ent_r;
    out_total_nxt = out_total_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;
    wrap          = head;
    in_tready     = 1'b0;

    unique case (state_r)
      ipnt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          req_nxt    = in_tuser;
          key_nxt    = ipnt_pkg::entry_t'(in_tdata);
          step_nxt   = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = ipnt_pkg::ST_SCAN;
        end
      end

      ipnt_pkg::ST_SCAN: begin
        if (slot_free) begin
          ctl.rotate = 1'b1;
          step_nxt   = step_r + 1'b1;
          if (step_r == CNT_W'(TABLE_DEPTH - 1)) begin
            state_nxt = ipnt_pkg::ST_DONE;
          end
          unique case (req_r)
            ipnt_pkg::REQ_LEARN: begin
              if (in_use && !pend_v_r && match) begin
                pend_v_nxt = 1'b1;
                wrap.mac   = key_r.mac;
                wrap.stamp = key_r.stamp;
              end
            end
            ipnt_pkg::REQ_FIND_IP, ipnt_pkg::REQ_FIND_MAC: begin
              if (in_use && !pend_v_r && match) begin
                pend_v_nxt = 1'b1;
                pend_nxt   = head;
              end
            end
            ipnt_pkg::REQ_DUMP: begin
              if (in_use && (head.ip[31:24] != 8'd0)) begin
                // the held beat is not last: a newer-to-older successor exists
                if (pend_v_r) begin
                  out_valid_nxt = 1'b1;
                  out_stat_nxt  = ipnt_pkg::STAT_HIT;
                  out_ent_nxt   = pend_r;
                  out_total_nxt = to_total(count_r);
                  out_last_nxt  = 1'b0;
                end
                pend_v_nxt = 1'b1;
                pend_nxt   = head;
              end
            end
            default: ;
          endcase
        end
      end

      ipnt_pkg::ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_ent_nxt   = '0;
          out_total_nxt = to_total(count_r);
          state_nxt     = ipnt_pkg::ST_IDLE;
          if (req_r == ipnt_pkg::REQ_LEARN) begin
            priority if (pend_v_r) begin
              out_stat_nxt = ipnt_pkg::STAT_HIT;
            end else if (count_r < CNT_W'(TABLE_DEPTH)) begin
              ctl.insert    = 1'b1;
              count_nxt     = count_r + 1'b1;
              out_total_nxt = to_total(count_r + 1'b1);
              out_stat_nxt  = ipnt_pkg::STAT_INS;
            end else begin
              out_stat_nxt = ipnt_pkg::STAT_FULL;
            end
          end else if (pend_v_r) begin
            out_stat_nxt = ipnt_pkg::STAT_HIT;
            out_ent_nxt  = pend_r;
          end else begin
            out_stat_nxt = ipnt_pkg::STAT_MISS;
          end
        end
      end

      default: state_nxt = ipnt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ipnt_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    req_r       <= req_nxt;
    key_r       <= key_nxt;
    pend_r      <= pend_nxt;
    out_stat_r  <= out_stat_nxt;
    out_ent_r   <= out_ent_nxt;
    out_total_r <= out_total_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {2'b00, out_total_r, out_ent_r.stamp, out_ent_r.mac, out_ent_r.ip};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + 1'b1))
    else $error("entry count moved by other than one insert");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ipnt_pkg::ST_SCAN && step_r == '0))
    else $error("accepted request did not start a scan");

  a_insert_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.insert |-> (state_r == ipnt_pkg::ST_DONE && !ctl.rotate))
    else $error("chain insert outside finish cycle");
`endif

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Testbench for the IP-to-MAC neighbor table: directed, random and table-full requests.
`timescale 1ns / 100ps
module testbench;

  localparam int DEPTH       = 32;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = DEPTH + 8;

  typedef struct packed {
    logic [1:0]                   status;
    logic [ipnt_pkg::IP_W-1:0]    ip;
    logic [ipnt_pkg::MAC_W-1:0]   mac;
    logic [ipnt_pkg::STAMP_W-1:0] stamp;
    logic [ipnt_pkg::TOTAL_W-1:0] total;
    logic                         last;
  } neighbor_reply_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [1:0]   in_tuser;   // [1:0] req_type
  logic [111:0] in_tdata;   // [31:0] ip, [79:32] mac, [111:80] stamp
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [1:0]   out_tuser;  // [1:0] status
  logic [119:0] out_tdata;  // [31:0] ip, [79:32] mac, [111:80] stamp, [117:112] total
  logic         out_tlast;

  // mirror of the table contents
  logic [ipnt_pkg::IP_W-1:0]    nbr_ip    [DEPTH];
  logic [ipnt_pkg::MAC_W-1:0]   nbr_mac   [DEPTH];
  logic [ipnt_pkg::STAMP_W-1:0] nbr_stamp [DEPTH];
  int                           nbr_count;

  neighbor_reply_t pending_replies[$];
  neighbor_reply_t want;

  int send_idle;
  int recv_idle;
  int errors;
  int replies_checked;
  int full_drops;
  int cycle_count;
  int req_seen [4];

  ip_mac_neighbor_table_core #(.TABLE_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d replies still pending", $time, pending_replies.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle);

  // ---------------- predictor ----------------

  // newest slot matching the key, -1 if none
  function automatic int find_slot(input bit by_mac, input logic [ipnt_pkg::IP_W-1:0] ip,
                                   input logic [ipnt_pkg::MAC_W-1:0] mac);
    for (int i = nbr_count - 1; i >= 0; i--)
      if (by_mac ? (nbr_mac[i] == mac) : (nbr_ip[i] == ip))
        return i;
    return -1;
  endfunction

  task automatic push_reply(input logic [1:0] status, input int slot, input bit fin);
    neighbor_reply_t r;
    r.status = status;
    r.ip     = (slot >= 0) ? nbr_ip[slot]    : '0;
    r.mac    = (slot >= 0) ? nbr_mac[slot]   : '0;
    r.stamp  = (slot >= 0) ? nbr_stamp[slot] : '0;
    r.total  = nbr_count[ipnt_pkg::TOTAL_W-1:0];
    r.last   = fin;
    pending_replies.push_back(r);
  endtask

  task automatic predict_neighbor_reply(input logic [1:0] kind,
                                        input logic [ipnt_pkg::IP_W-1:0] ip,
                                        input logic [ipnt_pkg::MAC_W-1:0] mac,
                                        input logic [ipnt_pkg::STAMP_W-1:0] stamp);
    int hit;
    int n;
    req_seen[kind]++;
    case (kind)
      ipnt_pkg::REQ_LEARN: begin
        hit = find_slot(1'b0, ip, mac);
        if (hit >= 0) begin
          nbr_stamp[hit] = stamp;
          nbr_mac[hit]   = mac;
          push_reply(ipnt_pkg::STAT_HIT, -1, 1'b1);
        end else if (nbr_count < DEPTH) begin
          nbr_ip[nbr_count]    = ip;
          nbr_mac[nbr_count]   = mac;
          nbr_stamp[nbr_count] = stamp;
          nbr_count++;
          push_reply(ipnt_pkg::STAT_INS, -1, 1'b1);
        end else begin
          full_drops++;
          push_reply(ipnt_pkg::STAT_FULL, -1, 1'b1);
        end
      end
      ipnt_pkg::REQ_FIND_IP, ipnt_pkg::REQ_FIND_MAC: begin
        hit = find_slot(kind == ipnt_pkg::REQ_FIND_MAC, ip, mac);
        push_reply((hit >= 0) ? ipnt_pkg::STAT_HIT : ipnt_pkg::STAT_MISS, hit, 1'b1);
      end
      default: begin
        n = 0;
        for (int i = nbr_count - 1; i >= 0; i--)
          if (nbr_ip[i][31:24] != 8'd0) begin
            push_reply(ipnt_pkg::STAT_HIT, i, 1'b0);
            n++;
          end
        if (n == 0)
          push_reply(ipnt_pkg::STAT_MISS, -1, 1'b1);
        else
          pending_replies[pending_replies.size()-1].last = 1'b1;
      end
    endcase
  endtask

  // ---------------- reply checker ----------------

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual status %h data %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        check_field("status", 64'(want.status), 64'(out_tuser));
        check_field("ip",     64'(want.ip),     64'(out_tdata[31:0]));
        check_field("mac",    64'(want.mac),    64'(out_tdata[79:32]));
        check_field("stamp",  64'(want.stamp),  64'(out_tdata[111:80]));
        check_field("total",  64'(want.total),  64'(out_tdata[117:112]));
        check_field("pad",    64'(2'b00),       64'(out_tdata[119:118]));
        check_field("last",   64'(want.last),   64'(out_tlast));
      end
    end
  end

  // ---------------- stimulus ----------------

  // called and returns at a falling edge
  task automatic send_request(input logic [1:0] kind, input logic [ipnt_pkg::IP_W-1:0] ip,
                              input logic [ipnt_pkg::MAC_W-1:0] mac,
                              input logic [ipnt_pkg::STAMP_W-1:0] stamp);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {stamp, mac, ip};
    do @(posedge clk); while (!in_tready);
    predict_neighbor_reply(kind, ip, mac, stamp);
    @(negedge clk);
  endtask

  task automatic wait_replies_drained();
    in_tvalid = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [ipnt_pkg::IP_W-1:0] fresh_ip(input bit zero_octet);
    logic [ipnt_pkg::IP_W-1:0] ip;
    do begin
      ip = $urandom;
      if (zero_octet) ip[31:24] = 8'd0;
    end while (find_slot(1'b0, ip, '0) >= 0);
    return ip;
  endfunction

  function automatic logic [ipnt_pkg::MAC_W-1:0] random_mac();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[ipnt_pkg::MAC_W-1:0];
  endfunction

  task automatic test_directed();
    send_request(ipnt_pkg::REQ_DUMP,     32'h0,         48'h0,            32'h0);  // empty
    send_request(ipnt_pkg::REQ_FIND_IP,  32'hC0A8_0001, 48'h0,            32'h0);
    send_request(ipnt_pkg::REQ_FIND_MAC, 32'h0,         48'h0,            32'h0);
    send_request(ipnt_pkg::REQ_LEARN,    32'h0,         48'h0,            32'h0);  // zero keys
    send_request(ipnt_pkg::REQ_LEARN,    32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ipnt_pkg::REQ_LEARN,    32'h0012_3456, 48'h0123_4567_89AB, 32'h1);
    send_request(ipnt_pkg::REQ_LEARN,    32'h0A00_0001, 48'h0123_4567_89AB, 32'h5);
    send_request(ipnt_pkg::REQ_LEARN,    32'h0100_0000, 48'h8000_0000_0001, 32'h8000_0000);
    send_request(ipnt_pkg::REQ_DUMP,     32'h0,         48'h0,            32'h0);
    send_request(ipnt_pkg::REQ_FIND_IP,  32'h0,         48'h1,            32'h0);
    send_request(ipnt_pkg::REQ_FIND_MAC, 32'h1,         48'h0,            32'h0);
    send_request(ipnt_pkg::REQ_FIND_MAC, 32'h0,         48'h0123_4567_89AB, 32'h0);
    send_request(ipnt_pkg::REQ_LEARN,    32'hFFFF_FFFF, 48'h5555_AAAA_5555, 32'h1234_5678);
    send_request(ipnt_pkg::REQ_FIND_IP,  32'hFFFF_FFFF, 48'h0,            32'h0);
    send_request(ipnt_pkg::REQ_FIND_MAC, 32'h0,         48'hFFFF_FFFF_FFFF, 32'h0);
    send_request(ipnt_pkg::REQ_LEARN,    32'h0,         48'hAAAA_5555_AAAA, 32'h7FFF_FFFF);
    send_request(ipnt_pkg::REQ_FIND_IP,  32'h0000_0001, 48'h0,            32'h0);
    send_request(ipnt_pkg::REQ_FIND_MAC, 32'h0,         48'hAAAA_5555_AAAA, 32'h0);
    send_request(ipnt_pkg::REQ_DUMP,     32'hDEAD_BEEF, 48'h1234,         32'h9);
  endtask

  task automatic test_random(input int count, input int tx_idle, input int rx_idle);
    logic [1:0]                 kind;
    logic [ipnt_pkg::IP_W-1:0]  ip;
    logic [ipnt_pkg::MAC_W-1:0] mac;
    int                         pick;
    send_idle = tx_idle;
    recv_idle = rx_idle;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      kind = (pick < 40) ? ipnt_pkg::REQ_LEARN : (pick < 65) ? ipnt_pkg::REQ_FIND_IP :
             (pick < 87) ? ipnt_pkg::REQ_FIND_MAC : ipnt_pkg::REQ_DUMP;
      ip   = $urandom;
      mac  = random_mac();
      if (nbr_count > 0 && $urandom_range(99) < 70) begin
        pick = $urandom_range(nbr_count - 1);
        ip   = nbr_ip[pick];
        if (kind != ipnt_pkg::REQ_LEARN) mac = nbr_mac[pick];
      end else if (kind == ipnt_pkg::REQ_LEARN) begin
        // keep fresh inserts rare so the table fills late
        ip = fresh_ip($urandom_range(9) == 0);
        if ($urandom_range(3) != 0 && nbr_count > 0)
          ip = nbr_ip[$urandom_range(nbr_count - 1)];
      end
      send_request(kind, ip, mac, $urandom);
      if (k % 20 == 19) wait_replies_drained();
    end
  endtask

  task automatic test_table_full();
    send_idle = 0;
    recv_idle = 0;
    while (nbr_count < DEPTH)
      send_request(ipnt_pkg::REQ_LEARN, fresh_ip(1'b0), random_mac(), $urandom);
    send_request(ipnt_pkg::REQ_LEARN, fresh_ip(1'b0), random_mac(), $urandom);  // dropped
    send_request(ipnt_pkg::REQ_LEARN, fresh_ip(1'b1), 48'h0, 32'h0);            // dropped
    send_request(ipnt_pkg::REQ_LEARN, nbr_ip[0], random_mac(), 32'hFFFF_FFFF);  // hit, full
    send_request(ipnt_pkg::REQ_FIND_IP, nbr_ip[0], 48'h0, 32'h0);
    send_request(ipnt_pkg::REQ_FIND_MAC, 32'h0, nbr_mac[DEPTH-1], 32'h0);
    send_request(ipnt_pkg::REQ_DUMP, 32'h0, 48'h0, 32'h0);
    recv_idle = 86;
    send_request(ipnt_pkg::REQ_DUMP, 32'h0, 48'h0, 32'h0);
    wait_replies_drained();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = ipnt_pkg::REQ_LEARN;
    in_tdata  = '0;
    send_idle = 27;
    recv_idle = 86;
    nbr_count = 0;
    errors    = 0;
    replies_checked = 0;
    full_drops  = 0;
    cycle_count = 0;
    req_seen  = '{default: 0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    wait_replies_drained();
    test_random(40, 27, 86);
    test_random(40, 86, 27);
    test_random(40, 0, 0);
    wait_replies_drained();
    test_table_full();

    if (pending_replies.size() != 0) begin
      $display("%0t: %0d expected replies never arrived", $time, pending_replies.size());
      errors++;
    end
    $display("requests: learn %0d, find-ip %0d, find-mac %0d, dump %0d; %0d replies checked",
             req_seen[ipnt_pkg::REQ_LEARN], req_seen[ipnt_pkg::REQ_FIND_IP],
             req_seen[ipnt_pkg::REQ_FIND_MAC], req_seen[ipnt_pkg::REQ_DUMP],
             replies_checked);
    $display("table filled to %0d entries, %0d learns dropped as full, %0d errors",
             nbr_count, full_drops, errors);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
